// ===== rtl/tpc_pkg.sv =====
// Shared widths, calibration constants, register indexes and types
// for the polynomial temperature converter. No dependencies.
`default_nettype none

package tpc_pkg;

    localparam int RawW    = 24;
    localparam int UW      = 32;
    localparam int CoefW   = 16;
    localparam int CW      = 28;
    localparam int TermW   = 60;
    localparam int SumW    = 62;
    localparam int FracOut = 40;
    localparam int MagW    = SumW + 1 - FracOut;
    localparam int TempW   = 16;
    localparam int CfgIdxW = 3;
    localparam int NumStg  = 9;

    // Scale factors of the linear, square, cube and fourth power terms, Q24
    localparam logic [CW-1:0] C1Q24 = CW'(109951163);
    localparam logic [CW-1:0] C2Q24 = CW'(144115188);
    localparam logic [CW-1:0] C3Q24 = CW'(188894659);
    localparam logic [CW-1:0] C4Q24 = CW'(61897002);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_K0 = 3'd0,
        CFG_K1 = 3'd1,
        CFG_K2 = 3'd2,
        CFG_K3 = 3'd3,
        CFG_K4 = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CoefW-1:0] k0;
        logic [CoefW-1:0] k1;
        logic [CoefW-1:0] k2;
        logic [CoefW-1:0] k3;
        logic [CoefW-1:0] k4;
    } t_coefs;

endpackage

`default_nettype wire

// ===== rtl/tpc_coef_regs.sv =====
// Calibration coefficient registers with a plain indexed write port.
// Depends on tpc_pkg.
`default_nettype none

module tpc_coef_regs
    import tpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [CoefW-1:0]   i_cfg_data,
    output t_coefs                  o_coefs
);

    t_coefs r_coefs;
    t_coefs n_coefs;

    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_K0:  n_coefs.k0 = i_cfg_data;
                CFG_K1:  n_coefs.k1 = i_cfg_data;
                CFG_K2:  n_coefs.k2 = i_cfg_data;
                CFG_K3:  n_coefs.k3 = i_cfg_data;
                CFG_K4:  n_coefs.k4 = i_cfg_data;
                default: n_coefs = r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    assign o_coefs = r_coefs;

endmodule

`default_nettype wire

// ===== rtl/temperature_polynomial_convert.sv =====
// Each accepted reading passes stage registers r1 to r9 to its result word.
// Throughput: one word per cycle while i_stall is low, nine-stage multiplier
// pipeline; a stalled output holds only the stages behind it, bubbles fill up.
// Reset clears all stage valid bits and the coefficient registers to zero.
// Depends on tpc_pkg and tpc_coef_regs.
`default_nettype none

module temperature_polynomial_convert
    import tpc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CfgIdxW-1:0]      i_cfg_idx,
    input  wire logic [CoefW-1:0]        i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [RawW-1:0]         i_raw_reading,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [TempW-1:0]      o_temperature_centi,
    output logic                         o_reading_valid
);

    t_coefs w_coefs;

    tpc_coef_regs u_coef_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coefs    (w_coefs)
    );

    logic [NumStg-1:0] r_v;
    logic [NumStg-1:0] w_en;
    logic [NumStg-1:0] r_nz;

    // advance a stage when it is empty or the one after it advances
    always_comb begin
        w_en[NumStg-1] = !r_v[NumStg-1] || !i_stall;
        for (int k = NumStg - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NumStg; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_nz[0] <= (i_raw_reading != '0);
        end
        for (int k = 1; k < NumStg; k++) begin
            if (w_en[k]) begin
                r_nz[k] <= r_nz[k-1];
            end
        end
    end

    // stage registers
    logic [UW-1:0]    r1_u1;
    logic [UW-1:0]    r2_u1, r2_u2, r2_m1;
    logic [UW-1:0]    r3_u1, r3_u3, r3_m2;
    logic [TermW-1:0] r3_t1;
    logic [UW-1:0]    r4_u4, r4_m3;
    logic [TermW-1:0] r4_t1, r4_t2;
    logic [UW-1:0]    r5_m4;
    logic [TermW-1:0] r5_t1, r5_t2, r5_t3;
    logic [TermW-1:0] r6_t2, r6_t4;
    logic [SumW-1:0]  r6_pos;
    logic [SumW-1:0]  r7_pos, r7_neg;
    logic             r8_sign;
    logic [SumW-1:0]  r8_diff;
    logic [TempW-1:0] r9_temp;

    // next values
    logic [2*UW-1:0]        n_sq2, n_sq3, n_sq4;
    logic [CoefW+UW-1:0]    n_km1, n_km2, n_km3, n_km4;
    logic [TermW-1:0]       n_t1, n_t2, n_t3, n_t4;
    logic [CoefW+1:0]       n_k0x3;
    logic [SumW-1:0]        n_k0term;
    logic [SumW-1:0]        n_pos, n_neg;
    logic                   n_sign;
    logic [SumW-1:0]        n_diff;
    logic [SumW:0]          n_rnd;
    logic [MagW-1:0]        n_mag;
    logic [TempW-1:0]       n_temp;

    always_comb begin
        n_sq2 = (2*UW)'(r1_u1) * (2*UW)'(r1_u1);
        n_km1 = (CoefW+UW)'(w_coefs.k1) * (CoefW+UW)'(r1_u1);

        n_sq3 = (2*UW)'(r2_u2) * (2*UW)'(r2_u1);
        n_km2 = (CoefW+UW)'(w_coefs.k2) * (CoefW+UW)'(r2_u2);
        n_t1  = TermW'(r2_m1) * TermW'(C1Q24);

        n_sq4 = (2*UW)'(r3_u3) * (2*UW)'(r3_u1);
        n_km3 = (CoefW+UW)'(w_coefs.k3) * (CoefW+UW)'(r3_u3);
        n_t2  = TermW'(r3_m2) * TermW'(C2Q24);

        n_km4 = (CoefW+UW)'(w_coefs.k4) * (CoefW+UW)'(r4_u4);
        n_t3  = TermW'(r4_m3) * TermW'(C3Q24);

        n_t4  = TermW'(r5_m4) * TermW'(C4Q24);
        n_pos = SumW'(r5_t1) + SumW'(r5_t3);

        n_k0x3   = {1'b0, w_coefs.k0, 1'b0} + (CoefW+2)'(w_coefs.k0);
        n_k0term = SumW'(n_k0x3) << (FracOut - 1);
        n_neg    = SumW'(r6_t2) + SumW'(r6_t4) + n_k0term;

        n_sign = (r7_pos < r7_neg);
        n_diff = n_sign ? (r7_neg - r7_pos) : (r7_pos - r7_neg);

        n_rnd = (SumW+1)'(r8_diff) + ((SumW+1)'(1) << (FracOut - 1));
        n_mag = n_rnd[SumW:FracOut];
        if (!r8_sign) begin
            n_temp = (n_mag > MagW'(32767)) ? TempW'(32767) : n_mag[TempW-1:0];
        end else begin
            n_temp = (n_mag > MagW'(32768)) ? TempW'(32768) : (~n_mag[TempW-1:0] + TempW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_u1 <= {i_raw_reading, 8'h00};
        end
        if (w_en[1]) begin
            r2_u1 <= r1_u1;
            r2_u2 <= n_sq2[2*UW-1:UW];
            r2_m1 <= n_km1[CoefW+UW-1:CoefW];
        end
        if (w_en[2]) begin
            r3_u1 <= r2_u1;
            r3_u3 <= n_sq3[2*UW-1:UW];
            r3_m2 <= n_km2[CoefW+UW-1:CoefW];
            r3_t1 <= n_t1;
        end
        if (w_en[3]) begin
            r4_u4 <= n_sq4[2*UW-1:UW];
            r4_m3 <= n_km3[CoefW+UW-1:CoefW];
            r4_t1 <= r3_t1;
            r4_t2 <= n_t2;
        end
        if (w_en[4]) begin
            r5_m4 <= n_km4[CoefW+UW-1:CoefW];
            r5_t1 <= r4_t1;
            r5_t2 <= r4_t2;
            r5_t3 <= n_t3;
        end
        if (w_en[5]) begin
            r6_t4  <= n_t4;
            r6_t2  <= r5_t2;
            r6_pos <= n_pos;
        end
        if (w_en[6]) begin
            r7_pos <= r6_pos;
            r7_neg <= n_neg;
        end
        if (w_en[7]) begin
            r8_sign <= n_sign;
            r8_diff <= n_diff;
        end
        if (w_en[8]) begin
            r9_temp <= n_temp;
        end
    end

    assign o_valid             = r_v[NumStg-1];
    assign o_temperature_centi = signed'(r9_temp);
    assign o_reading_valid     = r_nz[NumStg-1];

endmodule

`default_nettype wire
